/* rtl/rcm_pkg.sv */
// ----------------------------------------------------------------------------
// rcm_pkg: shared constants, codes and types
// Sizes, register indexes, status codes and the controller/datapath
// command and status structs of the row correlation block.
// ----------------------------------------------------------------------------
package rcm_pkg;

   // Store geometry
   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 256;
   localparam int ROW_W      = $clog2(MAX_ROWS);
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int NROW_W     = 7;
   localparam int NCOL_W     = 9;
   localparam int DATA_W     = 32;
   localparam int SAMPLE_W   = 16;
   localparam int CORR_W     = 16;
   localparam int STAT_W     = 2;

   // Arithmetic widths
   localparam int C_W        = 27;   // centered value n*x - S
   localparam int M_W        = 26;   // its magnitude
   localparam int SQ_W       = 2 * M_W;
   localparam int Q_W        = 64;   // sum of squares
   localparam int RT_W       = 62;   // square root working width
   localparam int H_W        = 5;    // even-shift count, shift of 2h bits
   localparam int CNT_W      = 5;
   localparam int ROOT_STEPS = 31;
   localparam int DIV_STEPS  = 32;
   localparam int Q_FRAC     = 30;   // Q1.30 store format
   localparam int CORR_SHIFT = 45;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'b1;

   // Item function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_ZVAR = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic             load;
      logic             sq_clr;
      logic             use_qry;
      logic             c_calc;
      logic             sq_mul;
      logic             sq_acc;
      logic             scale_step;
      logic             root_init;
      logic             root_step;
      logic             div_set;
      logic             div_step;
      logic             wr_norm;
      logic             wr_zero;
      logic             row_done;
      logic             qry_start;
      logic             qry_mul;
      logic             qry_acc;
      logic             qry_out;
      logic [COL_W-1:0] idx;
   } rcm_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic              row_full;
      logic              q_zero;
      logic              scaled;
      logic              qry_ok;
      logic              rsp_free;
      logic [NCOL_W-1:0] cols;
   } rcm_stat_type;

endpackage

/* rtl/rcm_if.sv */
// ----------------------------------------------------------------------------
// rcm_if: channel interfaces
// Item, result and register-write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface rcm_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic signed [rcm_pkg::SAMPLE_W-1:0] sample;
   logic [rcm_pkg::ROW_W-1:0]          row_a;
   logic [rcm_pkg::ROW_W-1:0]          row_b;
   modport source (output valid, func, sample, row_a, row_b, input ready);
   modport sink   (input valid, func, sample, row_a, row_b, output ready);
endinterface

interface rcm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [rcm_pkg::CORR_W-1:0] correlation;
   logic [rcm_pkg::STAT_W-1:0]        status;
   modport source (output valid, correlation, status, input ready);
   modport sink   (input valid, correlation, status, output ready);
endinterface

interface rcm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [rcm_pkg::CSR_IDX_W-1:0]   index;
   logic [rcm_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/row_correlation_matrix.sv */
// ----------------------------------------------------------------------------
// row_correlation_matrix: Pearson correlation of stored row pairs
// Loads a sample matrix row by row, normalizes each finished row in place
// and answers row-pair queries with a signed Q1.15 correlation.
// ----------------------------------------------------------------------------
// Load beat: one sample; the last beat of a row adds normalization of its n samples:
//   sum of squares, even shift, square root and a divide per sample, or
//   sum of squares and zero write-back at zero variance; set by the sequencer.
// Query: dot product into the result register; an error status skips the product.
// Reset is synchronous; the store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module row_correlation_matrix (
   input  logic       clock,
   input  logic       reset,
   rcm_req_if.sink    req_if,
   rcm_rsp_if.source  rsp_if,
   rcm_csr_if.sink    csr_if
);

   rcm_pkg::rcm_cmd_type  cmd;
   rcm_pkg::rcm_stat_type stat;
   logic                  req_ready;

   // Register writes are taken at any time
   assign csr_if.ready = 1'b1;
   assign req_if.ready = req_ready;

   rcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_func  (req_if.func),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rcm_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_sample      (req_if.sample),
      .req_row_a       (req_if.row_a),
      .req_row_b       (req_if.row_b),
      .csr_valid       (csr_if.valid),
      .csr_index       (csr_if.index),
      .csr_data        (csr_if.data),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_correlation (rsp_if.correlation),
      .rsp_status      (rsp_if.status)
   );

endmodule

/* rtl/rcm_ctrl.sv */
// ----------------------------------------------------------------------------
// rcm_ctrl: sequencer
// Walks the column loops of row normalization and row-pair queries and
// issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module rcm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_func,
   output logic                  req_ready,
   input  rcm_pkg::rcm_stat_type stat,
   output rcm_pkg::rcm_cmd_type  cmd
);

   typedef enum logic [16:0] {
      ST_IDLE    = 17'b00000000000000001,
      ST_SQ_RD   = 17'b00000000000000010,
      ST_SQ_C    = 17'b00000000000000100,
      ST_SQ_MUL  = 17'b00000000000001000,
      ST_SQ_ACC  = 17'b00000000000010000,
      ST_SCALE   = 17'b00000000000100000,
      ST_ROOT    = 17'b00000000001000000,
      ST_DV_RD   = 17'b00000000010000000,
      ST_DV_C    = 17'b00000000100000000,
      ST_DV_SET  = 17'b00000001000000000,
      ST_DV_DIV  = 17'b00000010000000000,
      ST_DV_WR   = 17'b00000100000000000,
      ST_ZERO_WR = 17'b00001000000000000,
      ST_QRY_RD  = 17'b00010000000000000,
      ST_QRY_MUL = 17'b00100000000000000,
      ST_QRY_ACC = 17'b01000000000000000,
      ST_QRY_OUT = 17'b10000000000000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [rcm_pkg::COL_W-1:0]   idx_ff, idx_in;
   logic [rcm_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        last_col;
   logic                        accept;

   assign last_col  = ({1'b0, idx_ff} == stat.cols - rcm_pkg::NCOL_W'(1));
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      cmd          = '0;
      cmd.idx      = idx_ff;
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept) begin
               if (req_func == rcm_pkg::FUNC_LOAD) begin
                  cmd.load = 1'b1;
                  if (stat.row_full) begin
                     cmd.sq_clr = 1'b1;
                     state_in   = ST_SQ_RD;
                  end
               end else begin
                  cmd.qry_start = 1'b1;
                  state_in      = stat.qry_ok ? ST_QRY_RD : ST_QRY_OUT;
               end
            end
         end
         ST_SQ_RD:  state_in = ST_SQ_C;
         ST_SQ_C: begin
            cmd.c_calc = 1'b1;
            state_in   = ST_SQ_MUL;
         end
         ST_SQ_MUL: begin
            cmd.sq_mul = 1'b1;
            state_in   = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            cmd.sq_acc = 1'b1;
            if (last_col) begin
               state_in = ST_SCALE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SQ_RD;
            end
         end
         ST_SCALE: begin
            idx_in = '0;
            cnt_in = '0;
            if (stat.q_zero) begin
               state_in = ST_ZERO_WR;
            end else if (stat.scaled) begin
               cmd.root_init = 1'b1;
               state_in      = ST_ROOT;
            end else begin
               cmd.scale_step = 1'b1;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == rcm_pkg::CNT_W'(rcm_pkg::ROOT_STEPS - 1)) begin
               state_in = ST_DV_RD;
            end
         end
         ST_DV_RD:  state_in = ST_DV_C;
         ST_DV_C: begin
            cmd.c_calc = 1'b1;
            state_in   = ST_DV_SET;
         end
         ST_DV_SET: begin
            cmd.div_set = 1'b1;
            cnt_in      = '0;
            state_in    = ST_DV_DIV;
         end
         ST_DV_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == rcm_pkg::CNT_W'(rcm_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DV_WR;
            end
         end
         ST_DV_WR: begin
            cmd.wr_norm = 1'b1;
            if (last_col) begin
               cmd.row_done = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_DV_RD;
            end
         end
         ST_ZERO_WR: begin
            cmd.wr_zero = 1'b1;
            if (last_col) begin
               cmd.row_done = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_QRY_RD: begin
            cmd.use_qry = 1'b1;
            state_in    = ST_QRY_MUL;
         end
         ST_QRY_MUL: begin
            cmd.use_qry = 1'b1;
            cmd.qry_mul = 1'b1;
            state_in    = ST_QRY_ACC;
         end
         ST_QRY_ACC: begin
            cmd.use_qry = 1'b1;
            cmd.qry_acc = 1'b1;
            if (last_col) begin
               state_in = ST_QRY_OUT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_QRY_RD;
            end
         end
         ST_QRY_OUT: begin
            if (stat.rsp_free) begin
               cmd.qry_out = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and loop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/rcm_dpath.sv */
// ----------------------------------------------------------------------------
// rcm_dpath: datapath
// Sample store, load counters, sum of squares, iterative square root,
// restoring divider, dot-product accumulator and result register.
// ----------------------------------------------------------------------------
module rcm_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  rcm_pkg::rcm_cmd_type                cmd,
   output rcm_pkg::rcm_stat_type               stat,
   input  logic signed [rcm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [rcm_pkg::ROW_W-1:0]           req_row_a,
   input  logic [rcm_pkg::ROW_W-1:0]           req_row_b,
   input  logic                                csr_valid,
   input  logic [rcm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rcm_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rcm_pkg::CORR_W-1:0]   rsp_correlation,
   output logic [rcm_pkg::STAT_W-1:0]          rsp_status
);

   // Configuration and load state
   logic [rcm_pkg::NROW_W-1:0]        num_rows_ff;
   logic [rcm_pkg::NCOL_W-1:0]        num_cols_ff;
   logic [rcm_pkg::NROW_W-1:0]        rows_eff;
   logic [rcm_pkg::NCOL_W-1:0]        cols_eff;
   logic [rcm_pkg::NROW_W-1:0]        load_row_ff;
   logic [rcm_pkg::NCOL_W-1:0]        load_col_ff;
   logic signed [rcm_pkg::DATA_W-1:0] row_sum_ff;
   logic [rcm_pkg::MAX_ROWS-1:0]      zvar_ff;
   logic                              load_ok;
   logic                              load_wr;

   // Store
   logic [rcm_pkg::DATA_W-1:0]        mem [rcm_pkg::MAX_ROWS * rcm_pkg::MAX_COLS];
   logic [rcm_pkg::DATA_W-1:0]        rd_a_ff, rd_b_ff;
   logic [rcm_pkg::ADDR_W-1:0]        addr_a, addr_b, waddr;
   logic [rcm_pkg::DATA_W-1:0]        wdata;
   logic                              we;

   // Normalization
   logic signed [rcm_pkg::C_W-1:0]    c_ff;
   logic signed [rcm_pkg::M_W-1:0]    nx;
   logic [rcm_pkg::M_W-1:0]           mag_c;
   logic [rcm_pkg::SQ_W-1:0]          sq_ff;
   logic [rcm_pkg::Q_W-1:0]           q_ff;
   logic [rcm_pkg::H_W-1:0]           h_ff;
   logic [rcm_pkg::RT_W-1:0]          v_ff, res_ff, bit_ff, rt_sum;
   logic [rcm_pkg::DATA_W-1:0]        r;
   logic [rcm_pkg::RT_W-1:0]          num, dvd;
   logic [5:0]                        shamt;
   logic [rcm_pkg::DATA_W-1:0]        rem_ff, dlo_ff, quo_ff;
   logic [rcm_pkg::DATA_W:0]          trial;
   logic                              neg_ff;
   logic [rcm_pkg::DATA_W-1:0]        qsat, norm_val;

   // Query
   logic [rcm_pkg::ROW_W-1:0]         qa_ff, qb_ff;
   logic [rcm_pkg::STAT_W-1:0]        code_ff, qcode;
   logic signed [2*rcm_pkg::DATA_W-1:0] qprod_ff, acc_ff;
   logic [2*rcm_pkg::DATA_W-1:0]      acc_mag;
   logic [2*rcm_pkg::DATA_W:0]        acc_rnd;
   logic [19:0]                       rq;
   logic signed [rcm_pkg::CORR_W-1:0] corr;
   logic                              rsp_valid_ff;
   logic signed [rcm_pkg::CORR_W-1:0] rsp_corr_ff;
   logic [rcm_pkg::STAT_W-1:0]        rsp_status_ff;

   // Clamp register values to their legal range
   assign rows_eff = (num_rows_ff == '0) ? rcm_pkg::NROW_W'(1) :
                     (num_rows_ff > rcm_pkg::NROW_W'(rcm_pkg::MAX_ROWS)) ?
                     rcm_pkg::NROW_W'(rcm_pkg::MAX_ROWS) : num_rows_ff;
   assign cols_eff = (num_cols_ff == '0) ? rcm_pkg::NCOL_W'(1) :
                     (num_cols_ff > rcm_pkg::NCOL_W'(rcm_pkg::MAX_COLS)) ?
                     rcm_pkg::NCOL_W'(rcm_pkg::MAX_COLS) : num_cols_ff;

   assign load_ok = (load_row_ff < rows_eff) && (load_col_ff < cols_eff);
   assign load_wr = cmd.load && load_ok;

   // Query checks: loading incomplete or index out of range first
   always_comb begin
      if (load_row_ff < rows_eff || {1'b0, req_row_a} >= rows_eff ||
          {1'b0, req_row_b} >= rows_eff) begin
         qcode = rcm_pkg::STAT_BAD;
      end else if (zvar_ff[req_row_a] || zvar_ff[req_row_b]) begin
         qcode = rcm_pkg::STAT_ZVAR;
      end else begin
         qcode = rcm_pkg::STAT_OK;
      end
   end

   assign stat.row_full = load_ok && (load_col_ff == cols_eff - rcm_pkg::NCOL_W'(1));
   assign stat.q_zero   = (q_ff == '0);
   assign stat.scaled   = (q_ff[rcm_pkg::Q_W-1:60] != '0);
   assign stat.qry_ok   = (qcode == rcm_pkg::STAT_OK);
   assign stat.rsp_free = !rsp_valid_ff;
   assign stat.cols     = cols_eff;

   // Registers, load counters and zero-variance flags
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= rcm_pkg::NROW_W'(rcm_pkg::MAX_ROWS);
         num_cols_ff <= rcm_pkg::NCOL_W'(rcm_pkg::MAX_COLS);
         load_row_ff <= '0;
         load_col_ff <= '0;
         row_sum_ff  <= '0;
         zvar_ff     <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            rcm_pkg::CSR_NUM_ROWS: num_rows_ff <= csr_data[rcm_pkg::NROW_W-1:0];
            rcm_pkg::CSR_NUM_COLS: num_cols_ff <= csr_data;
            default: ;
         endcase
         load_row_ff <= '0;
         load_col_ff <= '0;
         row_sum_ff  <= '0;
         zvar_ff     <= '0;
      end else begin
         if (load_wr) begin
            load_col_ff <= load_col_ff + 1'b1;
            row_sum_ff  <= row_sum_ff + rcm_pkg::DATA_W'(req_sample);
         end
         if (cmd.row_done) begin
            load_row_ff                            <= load_row_ff + 1'b1;
            load_col_ff                            <= '0;
            row_sum_ff                             <= '0;
            zvar_ff[load_row_ff[rcm_pkg::ROW_W-1:0]] <= stat.q_zero;
         end
      end
   end

   // Store addressing
   assign addr_a = {cmd.use_qry ? qa_ff : load_row_ff[rcm_pkg::ROW_W-1:0], cmd.idx};
   assign addr_b = {qb_ff, cmd.idx};
   assign waddr  = cmd.load ?
                   {load_row_ff[rcm_pkg::ROW_W-1:0], load_col_ff[rcm_pkg::COL_W-1:0]} :
                   {load_row_ff[rcm_pkg::ROW_W-1:0], cmd.idx};
   assign we     = load_wr || cmd.wr_norm || cmd.wr_zero;
   assign wdata  = cmd.load ? rcm_pkg::DATA_W'(req_sample) :
                   cmd.wr_norm ? norm_val : '0;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
   end

   // Centered value c = n*x - S and its magnitude
   assign nx    = $signed({1'b0, cols_eff}) * $signed(rd_a_ff[rcm_pkg::SAMPLE_W-1:0]);
   assign mag_c = c_ff[rcm_pkg::C_W-1] ? rcm_pkg::M_W'(-c_ff) : rcm_pkg::M_W'(c_ff);

   // Sum of squares, even shift into [2^60, 2^62)
   always_ff @(posedge clock) begin
      if (cmd.c_calc) begin
         c_ff <= rcm_pkg::C_W'(nx) - rcm_pkg::C_W'(row_sum_ff);
      end
      if (cmd.sq_mul) begin
         sq_ff <= mag_c * mag_c;
      end
      if (cmd.sq_clr) begin
         q_ff <= '0;
         h_ff <= '0;
      end else if (cmd.sq_acc) begin
         q_ff <= q_ff + rcm_pkg::Q_W'(sq_ff);
      end else if (cmd.scale_step) begin
         q_ff <= q_ff << 2;
         h_ff <= h_ff + 1'b1;
      end
   end

   // Floor square root, one result bit per step
   assign rt_sum = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         v_ff   <= q_ff[rcm_pkg::RT_W-1:0];
         res_ff <= '0;
         bit_ff <= rcm_pkg::RT_W'(1) << 60;
      end else if (cmd.root_step) begin
         if (v_ff >= rt_sum) begin
            v_ff   <= v_ff - rt_sum;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // Rounded divide (m * 2^(30+h) + r/2) / r, one quotient bit per step
   assign r     = res_ff[rcm_pkg::DATA_W-1:0];
   assign shamt = 6'(rcm_pkg::Q_FRAC) + 6'(h_ff);
   assign num   = rcm_pkg::RT_W'(mag_c) << shamt;
   assign dvd   = num + rcm_pkg::RT_W'(r >> 1);
   assign trial = {rem_ff, dlo_ff[rcm_pkg::DATA_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_set) begin
         rem_ff <= rcm_pkg::DATA_W'(dvd[rcm_pkg::RT_W-1:rcm_pkg::DATA_W]);
         dlo_ff <= dvd[rcm_pkg::DATA_W-1:0];
         quo_ff <= '0;
         neg_ff <= c_ff[rcm_pkg::C_W-1];
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, r}) begin
            rem_ff <= rcm_pkg::DATA_W'(trial - {1'b0, r});
            quo_ff <= {quo_ff[rcm_pkg::DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[rcm_pkg::DATA_W-1:0];
            quo_ff <= {quo_ff[rcm_pkg::DATA_W-2:0], 1'b0};
         end
         dlo_ff <= dlo_ff << 1;
      end
   end

   // Clamp to 2^31-1 and restore sign
   assign qsat     = quo_ff[rcm_pkg::DATA_W-1] ? {1'b0, {(rcm_pkg::DATA_W-1){1'b1}}} : quo_ff;
   assign norm_val = neg_ff ? -qsat : qsat;

   // Dot product of the two rows
   always_ff @(posedge clock) begin
      if (cmd.qry_start) begin
         qa_ff   <= req_row_a;
         qb_ff   <= req_row_b;
         code_ff <= qcode;
         acc_ff  <= '0;
      end else if (cmd.qry_acc) begin
         acc_ff <= acc_ff + qprod_ff;
      end
      if (cmd.qry_mul) begin
         qprod_ff <= $signed(rd_a_ff) * $signed(rd_b_ff);
      end
   end

   // Round by 2^45 half away from zero, saturate to Q1.15
   assign acc_mag = acc_ff[2*rcm_pkg::DATA_W-1] ? -acc_ff : acc_ff;
   assign acc_rnd = {1'b0, acc_mag} + ((2*rcm_pkg::DATA_W+1)'(1) << (rcm_pkg::CORR_SHIFT - 1));
   assign rq      = 20'(acc_rnd >> rcm_pkg::CORR_SHIFT);

   always_comb begin
      if (acc_ff[2*rcm_pkg::DATA_W-1]) begin
         corr = (rq > 20'd32768) ? -16'sd32768 : rcm_pkg::CORR_W'(-rq);
      end else begin
         corr = (rq > 20'd32767) ? 16'sd32767 : rcm_pkg::CORR_W'(rq);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.qry_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.qry_out) begin
         rsp_corr_ff   <= (code_ff == rcm_pkg::STAT_OK) ? corr : '0;
         rsp_status_ff <= code_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_correlation = rsp_corr_ff;
   assign rsp_status      = rsp_status_ff;

   // Never overwrite a pending result beat
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.qry_out |-> !rsp_valid_ff)
      else $error("result overwritten while pending");

   // Sum of squares lies in [2^60, 2^62) when the root starts
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      cmd.root_init |-> (q_ff[63:62] == 2'b00 && q_ff[61:60] != 2'b00))
      else $error("sum of squares not scaled");

   // Root lies in [2^30, 2^31) when division starts
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_set |-> (res_ff[rcm_pkg::RT_W-1:31] == '0 && res_ff[30]))
      else $error("divisor out of range");

   // Remainder stays below the divisor at write-back
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_norm |-> (rem_ff < r))
      else $error("divider remainder not reduced");

endmodule
